// ===== src/tile_map_scroll_renderer_top_macros.svh =====
// assertion macros used by the checker file
`ifndef TILE_MAP_SCROLL_RENDERER_TOP_MACROS_SVH
`define TILE_MAP_SCROLL_RENDERER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TMSR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TMSR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tmsr_pkg.sv =====
// shared constants and types for the tile map scroll renderer
package tmsr_pkg;

  localparam int MAP_COLUMNS  = 32;
  localparam int DISPLAY_ROWS = 8;
  localparam int ROW_BYTES    = 128;
  localparam int TILE_COUNT   = 256;
  localparam int TILE_BYTES   = 8;

  localparam int MAP_DEPTH = DISPLAY_ROWS * MAP_COLUMNS;
  localparam int PAT_DEPTH = TILE_COUNT * TILE_BYTES;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int PAT_AW    = $clog2(PAT_DEPTH);
  localparam int TCOL_W    = $clog2(MAP_COLUMNS);
  localparam int TILE_W    = $clog2(TILE_COUNT);
  localparam int BYTE_W    = $clog2(TILE_BYTES);

  // fixed port field widths
  localparam int ACTION_W = 3;
  localparam int ROW_W    = 3;
  localparam int COLUMN_W = 7;
  localparam int ADDR_W   = 11;
  localparam int DATA_W   = 8;
  localparam int SCROLL_W = 8;
  localparam int COARSE_W = 5;
  localparam int FINE_W   = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_MAP_WR    = 3'd0,
    ACT_PAT_WR    = 3'd1,
    ACT_ROW_SCRL  = 3'd2,
    ACT_ALL_SCRL  = 3'd3,
    ACT_RENDER    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MAP  = 2'd1,
    ST_PAT  = 2'd2
  } state_e;

endpackage

// ===== src/tmsr_ram.sv =====
// generic single-write, single-read ram with registered read data
module tmsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tile_map_scroll_renderer_top.sv =====
// tile map background renderer with per-row horizontal scroll
//
// Usage:
//   A command is transferred at a rising clock edge where start is high and
//   busy is low. action_i selects: write map entry, write pattern byte, set
//   the scroll of one row, set the scroll of all rows, or render one byte.
//   Write and scroll commands complete at their transfer edge and give no
//   result; busy stays low, so a command may follow in the next cycle.
//   A render command raises busy while the map entry is read from the map
//   ram, then the pattern byte from the pattern ram. The result
//   (pixel_byte_o, out_row_o, out_column_o) is shown for one cycle with
//   out_strobe_o high, from the output register after the pattern read.
//   Throughput: one write per cycle while busy is low; a new render is taken
//   only once the last one's dependent map read then pattern read is through.
//   The output register frees the pipeline, so a new command may be taken in
//   the cycle the result is shown. The receiver cannot stall the result.
//   Reset clears all row scroll positions to zero and the control state;
//   the map and pattern rams hold no defined data until written.
module tile_map_scroll_renderer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [tmsr_pkg::ACTION_W-1:0] action_i,
  input  logic [tmsr_pkg::ROW_W-1:0]    row_i,
  input  logic [tmsr_pkg::COLUMN_W-1:0] column_i,
  input  logic [tmsr_pkg::ADDR_W-1:0]   address_i,
  input  logic [tmsr_pkg::DATA_W-1:0]   write_value_i,
  input  logic [tmsr_pkg::SCROLL_W-1:0] scroll_position_i,
  output logic                          out_strobe_o,
  output logic [tmsr_pkg::DATA_W-1:0]   pixel_byte_o,
  output logic [tmsr_pkg::ROW_W-1:0]    out_row_o,
  output logic [tmsr_pkg::COLUMN_W-1:0] out_column_o
);

  import tmsr_pkg::*;

  state_e state_q, state_d;
  action_e act;

  logic [COARSE_W-1:0] row_coarse_q [DISPLAY_ROWS];
  logic [FINE_W-1:0]   row_fine_q   [DISPLAY_ROWS];

  logic                accept;
  logic                row_ok;
  logic                col_ok;
  logic                render_go;
  logic                map_we;
  logic                pat_we;
  logic                map_re;
  logic                pat_re;
  logic [COLUMN_W:0]   pos;
  logic [TCOL_W-1:0]   tcol;
  logic [MAP_AW-1:0]   map_raddr;
  logic [PAT_AW-1:0]   pat_raddr;
  logic [DATA_W-1:0]   map_rdata;
  logic [DATA_W-1:0]   pat_rdata;

  logic [BYTE_W-1:0]   byte_q, byte_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [COLUMN_W-1:0] col_q, col_d;
  logic                strobe_q, strobe_d;
  logic [DATA_W-1:0]   pixel_q, pixel_d;
  logic [ROW_W-1:0]    orow_q, orow_d;
  logic [COLUMN_W-1:0] ocol_q, ocol_d;

  // command decode
  assign act    = action_e'(action_i);
  assign accept = start && !busy;
  assign row_ok = ({1'b0, row_i} < (ROW_W + 1)'(DISPLAY_ROWS));
  assign col_ok = ({1'b0, column_i} < (COLUMN_W + 1)'(ROW_BYTES));

  always_comb begin
    render_go = 1'b0;
    map_we    = 1'b0;
    pat_we    = 1'b0;
    case (act)
      ACT_MAP_WR: map_we    = accept && ({1'b0, address_i} < (ADDR_W + 1)'(MAP_DEPTH));
      ACT_PAT_WR: pat_we    = accept && ({1'b0, address_i} < (ADDR_W + 1)'(PAT_DEPTH));
      ACT_RENDER: render_go = accept && row_ok && col_ok;
      default: begin
      end
    endcase
  end

  // scroll position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < DISPLAY_ROWS; r++) begin
        row_coarse_q[r] <= '0;
        row_fine_q[r]   <= '0;
      end
    end else if (accept) begin
      for (int r = 0; r < DISPLAY_ROWS; r++) begin
        if ((act == ACT_ALL_SCRL) ||
            ((act == ACT_ROW_SCRL) && row_ok && (row_i == ROW_W'(r)))) begin
          row_coarse_q[r] <= scroll_position_i[SCROLL_W-1:FINE_W];
          row_fine_q[r]   <= scroll_position_i[FINE_W-1:0];
        end
      end
    end
  end

  // scrolled tile column and byte within the tile
  assign pos       = (COLUMN_W + 1)'(row_fine_q[row_i]) + (COLUMN_W + 1)'(column_i);
  assign tcol      = TCOL_W'(row_coarse_q[row_i] + COARSE_W'(pos[COLUMN_W:BYTE_W]));
  assign map_raddr = {row_i, tcol};
  assign pat_raddr = {map_rdata[TILE_W-1:0], byte_q};

  tmsr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (address_i[MAP_AW-1:0]),
    .wdata_i (write_value_i),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  tmsr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (PAT_DEPTH)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (address_i[PAT_AW-1:0]),
    .wdata_i (write_value_i),
    .re_i    (pat_re),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (render_go) state_d = ST_MAP;
      ST_MAP:  state_d = ST_PAT;
      ST_PAT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs, map read runs every idle cycle and holds while busy
  always_comb begin
    busy   = 1'b0;
    map_re = 1'b0;
    pat_re = 1'b0;
    case (state_q)
      ST_IDLE: map_re = 1'b1;
      ST_MAP: begin
        busy   = 1'b1;
        pat_re = 1'b1;
      end
      ST_PAT:  busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  // render context and result register
  always_comb begin
    byte_d   = byte_q;
    row_d    = row_q;
    col_d    = col_q;
    pixel_d  = pixel_q;
    orow_d   = orow_q;
    ocol_d   = ocol_q;
    strobe_d = (state_q == ST_PAT);
    if (render_go) begin
      byte_d = pos[BYTE_W-1:0];
      row_d  = row_i;
      col_d  = column_i;
    end
    if (state_q == ST_PAT) begin
      pixel_d = pat_rdata;
      orow_d  = row_q;
      ocol_d  = col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    row_q   <= row_d;
    col_q   <= col_d;
    pixel_q <= pixel_d;
    orow_q  <= orow_d;
    ocol_q  <= ocol_d;
  end

  assign out_strobe_o = strobe_q;
  assign pixel_byte_o = pixel_q;
  assign out_row_o    = orow_q;
  assign out_column_o = ocol_q;

endmodule

// ===== src/tmsr_checker.sv =====
// port-level checker for the renderer, bound to the top level
`include "tile_map_scroll_renderer_top_macros.svh"

module tmsr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [tmsr_pkg::ACTION_W-1:0] action_i,
  input logic                          out_strobe_o
);

  import tmsr_pkg::*;

  logic render_xfer;
  logic other_xfer;

  assign render_xfer = start && !busy && (action_i == ACT_RENDER);
  assign other_xfer  = start && !busy && (action_i != ACT_RENDER);

  // a render transfer holds off further commands
  `TMSR_ASSERT_NXT(a_render_busy, clk_i, rst_ni, render_xfer, busy, "render did not raise busy")

  // write, scroll and unused action commands finish at once
  `TMSR_ASSERT_NXT(a_write_free, clk_i, rst_ni, other_xfer, !busy && !out_strobe_o, "write command stalled")

  // a render result arrives after the two ram reads
  `TMSR_ASSERT_IMP(a_render_result, clk_i, rst_ni, render_xfer, ##3 out_strobe_o, "render result missing")

  // results never come back to back and only after a busy period
  `TMSR_ASSERT_NXT(a_strobe_single, clk_i, rst_ni, out_strobe_o, !out_strobe_o, "strobe held two cycles")
  `TMSR_ASSERT_IMP(a_strobe_src, clk_i, rst_ni, out_strobe_o, $past(busy) && !busy, "strobe without render")

endmodule

bind tile_map_scroll_renderer_top tmsr_checker u_tmsr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .action_i     (action_i),
  .out_strobe_o (out_strobe_o)
);

// ===== tb/sv/tb_tile_map_scroll_renderer_top.sv =====
// testbench for the tile map scroll renderer: directed table, then random traffic vs a local model
`timescale 1ns / 100ps

module tb_tile_map_scroll_renderer_top;
  import tmsr_pkg::*;

  // action codes the block leaves unused
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 400;
  localparam int PAUSE_EVERY  = 120;
  localparam int IDLE_LIMIT   = 500;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ROW_W-1:0]    row;
    logic [COLUMN_W-1:0] column;
    logic [ADDR_W-1:0]   address;
    logic [DATA_W-1:0]   value;
    logic [SCROLL_W-1:0] scroll;
  } command_t;

  typedef struct packed {
    logic [DATA_W-1:0]   pixels;
    logic [ROW_W-1:0]    row;
    logic [COLUMN_W-1:0] column;
  } pixel_result_t;

  typedef struct {
    command_t          cmd;
    bit                typed;
    logic [DATA_W-1:0] pixels;
  } plan_entry_t;

  logic                clk_i;
  logic                rst_ni            = 1'b0;
  logic                start             = 1'b0;
  logic                busy;
  logic [ACTION_W-1:0] action_i          = '0;
  logic [ROW_W-1:0]    row_i             = '0;
  logic [COLUMN_W-1:0] column_i          = '0;
  logic [ADDR_W-1:0]   address_i         = '0;
  logic [DATA_W-1:0]   write_value_i     = '0;
  logic [SCROLL_W-1:0] scroll_position_i = '0;
  logic                out_strobe_o;
  logic [DATA_W-1:0]   pixel_byte_o;
  logic [ROW_W-1:0]    out_row_o;
  logic [COLUMN_W-1:0] out_column_o;

  tile_map_scroll_renderer_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .action_i          (action_i),
    .row_i             (row_i),
    .column_i          (column_i),
    .address_i         (address_i),
    .write_value_i     (write_value_i),
    .scroll_position_i (scroll_position_i),
    .out_strobe_o      (out_strobe_o),
    .pixel_byte_o      (pixel_byte_o),
    .out_row_o         (out_row_o),
    .out_column_o      (out_column_o)
  );

  // shadow copy of the renderer state
  logic [DATA_W-1:0]   map_shadow     [MAP_DEPTH];
  bit                  map_known      [MAP_DEPTH];
  logic [DATA_W-1:0]   pattern_shadow [PAT_DEPTH];
  bit                  pattern_known  [PAT_DEPTH];
  logic [COARSE_W-1:0] coarse_shadow  [DISPLAY_ROWS];
  logic [FINE_W-1:0]   fine_shadow    [DISPLAY_ROWS];

  pixel_result_t pending_bytes[$];

  int fail_count     = 0;
  int bytes_checked  = 0;
  int commands_sent  = 0;
  int items_done     = 0;
  int drain_pauses   = 0;
  int burst_left     = 0;
  bit pause_due      = 1'b0;
  int idle_cycles    = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // map entry that a render of this row and column reads
  function automatic int map_slot(logic [ROW_W-1:0] row, logic [COLUMN_W-1:0] col);
    int p;
    int tcol;
    p    = int'(fine_shadow[row]) + int'(col);
    tcol = (int'(coarse_shadow[row]) + (p >> 3)) % MAP_COLUMNS;
    return int'(row) * MAP_COLUMNS + tcol;
  endfunction

  // pattern byte that a render of this row and column reads
  function automatic int pattern_slot(logic [ROW_W-1:0] row, logic [COLUMN_W-1:0] col);
    int p;
    int tile;
    p    = int'(fine_shadow[row]) + int'(col);
    tile = int'(map_shadow[MAP_AW'(map_slot(row, col))]) % TILE_COUNT;
    return tile * TILE_BYTES + (p % TILE_BYTES);
  endfunction

  // apply one transferred command to the shadow state, give the rendered byte if any
  task automatic predict_command(input command_t c, output bit renders,
                                 output pixel_result_t res);
    renders = 1'b0;
    res     = '0;
    case (c.action)
      ACT_MAP_WR: begin
        if (c.address < MAP_DEPTH) begin
          map_shadow[c.address[MAP_AW-1:0]] = c.value;
          map_known[c.address[MAP_AW-1:0]]  = 1'b1;
        end
      end
      ACT_PAT_WR: begin
        if (c.address < PAT_DEPTH) begin
          pattern_shadow[c.address] = c.value;
          pattern_known[c.address]  = 1'b1;
        end
      end
      ACT_ROW_SCRL, ACT_ALL_SCRL: begin
        for (int r = 0; r < DISPLAY_ROWS; r++) begin
          if (c.action == ACT_ALL_SCRL || r == int'(c.row)) begin
            coarse_shadow[r] = c.scroll[7:3];
            fine_shadow[r]   = c.scroll[2:0];
          end
        end
      end
      ACT_RENDER: begin
        if (c.row < DISPLAY_ROWS && c.column < ROW_BYTES) begin
          renders    = 1'b1;
          res.pixels = pattern_shadow[PAT_AW'(pattern_slot(c.row, c.column))];
          res.row    = c.row;
          res.column = c.column;
        end
      end
      default: ;
    endcase
  endtask

  function automatic command_t random_command();
    command_t c;
    c.action  = ACT_SPARE_HI;
    c.row     = ROW_W'($urandom);
    c.column  = COLUMN_W'($urandom);
    c.address = ADDR_W'($urandom);
    c.value   = DATA_W'($urandom);
    c.scroll  = SCROLL_W'($urandom);
    return c;
  endfunction

  // one command transfer, with burst pacing in front of it
  task automatic transfer(input command_t c, input bit typed = 1'b0,
                          input logic [DATA_W-1:0] typed_pixels = '0);
    bit            renders;
    pixel_result_t res;
    if (burst_left <= 0 || pause_due) begin
      start <= 1'b0;
      if (pause_due) begin
        pause_due = 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk_i);
        drain_pauses++;
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(4, 12)) @(posedge clk_i);
      else repeat ($urandom_range(1, 3)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    start             <= 1'b1;
    action_i          <= c.action;
    row_i             <= c.row;
    column_i          <= c.column;
    address_i         <= c.address;
    write_value_i     <= c.value;
    scroll_position_i <= c.scroll;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_command(c, renders, res);
    if (renders) begin
      if (typed) res.pixels = typed_pixels;
      pending_bytes.push_back(res);
    end
    commands_sent++;
    if (!(c.action > ACT_RENDER || (c.action == ACT_MAP_WR && c.address >= MAP_DEPTH)))
      items_done++;
  endtask

  // render one byte, writing first whatever map entry or pattern byte it reads unwritten
  task automatic render_filled(input logic [ROW_W-1:0] row, input logic [COLUMN_W-1:0] col);
    command_t c;
    int       slot;
    slot = map_slot(row, col);
    if (!map_known[MAP_AW'(slot)]) begin
      c         = random_command();
      c.action  = ACT_MAP_WR;
      c.address = ADDR_W'(slot);
      transfer(c);
    end
    slot = pattern_slot(row, col);
    if (!pattern_known[PAT_AW'(slot)]) begin
      c         = random_command();
      c.action  = ACT_PAT_WR;
      c.address = ADDR_W'(slot);
      transfer(c);
    end
    c        = random_command();
    c.action = ACT_RENDER;
    c.row    = row;
    c.column = col;
    transfer(c);
  endtask

  function automatic plan_entry_t plan_step(logic [ACTION_W-1:0] act, logic [ROW_W-1:0] row,
                                            logic [COLUMN_W-1:0] col, logic [ADDR_W-1:0] addr,
                                            logic [DATA_W-1:0] val, logic [SCROLL_W-1:0] scrl,
                                            bit typed, logic [DATA_W-1:0] pixels);
    plan_entry_t e;
    e.cmd    = '{act, row, col, addr, val, scrl};
    e.typed  = typed;
    e.pixels = pixels;
    return e;
  endfunction

  // result checker: every strobe must match the oldest expected byte
  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni === 1'b1 && out_strobe_o === 1'b1) begin
      if (pending_bytes.size() == 0) begin
        $error("result with nothing expected: pixel_byte %0h row %0d column %0d",
               pixel_byte_o, out_row_o, out_column_o);
        fail_count++;
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (pixel_byte_o !== want.pixels) begin
          $error("pixel_byte: expected %0h, got %0h", want.pixels, pixel_byte_o);
          fail_count++;
        end
        if (out_row_o !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_row_o);
          fail_count++;
        end
        if (out_column_o !== want.column) begin
          $error("out_column: expected %0d, got %0d", want.column, out_column_o);
          fail_count++;
        end
      end
    end
  end

  // cycles with neither a command nor a result transfer
  always @(posedge clk_i) begin
    if ((start === 1'b1 && busy === 1'b0) || out_strobe_o === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $error("no transfer for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    plan_entry_t plan[$];
    command_t    c;
    int          pick;
    int          target;
    int          next_pause;
    logic [ROW_W-1:0]    r;
    logic [COLUMN_W-1:0] col;

    for (int i = 0; i < DISPLAY_ROWS; i++) begin
      coarse_shadow[i] = '0;
      fine_shadow[i]   = '0;
    end

    // reset
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table: extremes, out-of-range writes, wrap, fine crossing, unused actions
    plan.push_back(plan_step(ACT_MAP_WR,   3'd0, 7'd0,   11'd0,    8'hFF, 8'h00, 1'b0, 8'h00));
    plan.push_back(plan_step(ACT_PAT_WR,   3'd0, 7'd0,   11'd2040, 8'hA5, 8'h00, 1'b0, 8'h00));
    plan.push_back(plan_step(ACT_RENDER,   3'd0, 7'd0,   11'd0,    8'h00, 8'h00, 1'b1, 8'hA5));
    // map address past the end must not alias onto entry zero
    plan.push_back(plan_step(ACT_MAP_WR,   3'd0, 7'd0,   11'd256,  8'h01, 8'h00, 1'b0, 8'h00));
    plan.push_back(plan_step(ACT_RENDER,   3'd0, 7'd0,   11'd0,    8'h00, 8'h00, 1'b1, 8'hA5));
    plan.push_back(plan_step(ACT_MAP_WR,   3'd0, 7'd0,   11'd255,  8'h00, 8'h00, 1'b0, 8'h00));
    plan.push_back(plan_step(ACT_PAT_WR,   3'd0, 7'd0,   11'd7,    8'h3C, 8'h00, 1'b0, 8'h00));
    plan.push_back(plan_step(ACT_ROW_SCRL, 3'd7, 7'd0,   11'd0,    8'h00, 8'hFF, 1'b0, 8'h00));
    plan.push_back(plan_step(ACT_RENDER,   3'd7, 7'd0,   11'd0,    8'h00, 8'h00, 1'b1, 8'h3C));
    plan.push_back(plan_step(ACT_MAP_WR,   3'd0, 7'd0,   11'd239,  8'h80, 8'h00, 1'b0, 8'h00));
    plan.push_back(plan_step(ACT_PAT_WR,   3'd0, 7'd0,   11'd1030, 8'h00, 8'h00, 1'b0, 8'h00));
    // last column with full scroll, tile column wraps
    plan.push_back(plan_step(ACT_RENDER,   3'd7, 7'd127, 11'd0,    8'h00, 8'h00, 1'b0, 8'h00));
    plan.push_back(plan_step(ACT_MAP_WR,   3'd0, 7'd0,   11'd2047, 8'h80, 8'h00, 1'b0, 8'h00));
    plan.push_back(plan_step(ACT_RENDER,   3'd7, 7'd0,   11'd0,    8'h00, 8'h00, 1'b1, 8'h3C));
    plan.push_back(plan_step(ACT_ALL_SCRL, 3'd0, 7'd0,   11'd0,    8'h00, 8'hF8, 1'b0, 8'h00));
    plan.push_back(plan_step(ACT_RENDER,   3'd0, 7'd8,   11'd0,    8'h00, 8'h00, 1'b1, 8'hA5));
    plan.push_back(plan_step(ACT_RENDER,   3'd7, 7'd7,   11'd0,    8'h00, 8'h00, 1'b1, 8'h3C));
    // unused actions with every field at its extremes
    plan.push_back(plan_step(ACT_SPARE_HI, 3'd7, 7'd127, 11'd2047, 8'hFF, 8'hFF, 1'b0, 8'h00));
    plan.push_back(plan_step(ACT_SPARE_LO, 3'd0, 7'd0,   11'd0,    8'h00, 8'h00, 1'b0, 8'h00));
    plan.push_back(plan_step(ACT_RENDER,   3'd0, 7'd8,   11'd0,    8'h00, 8'h00, 1'b1, 8'hA5));
    // fine offset carries into the next tile column
    plan.push_back(plan_step(ACT_ROW_SCRL, 3'd2, 7'd0,   11'd0,    8'h00, 8'h07, 1'b0, 8'h00));
    plan.push_back(plan_step(ACT_MAP_WR,   3'd0, 7'd0,   11'd65,   8'hFF, 8'h00, 1'b0, 8'h00));
    plan.push_back(plan_step(ACT_RENDER,   3'd2, 7'd1,   11'd0,    8'h00, 8'h00, 1'b0, 8'h00));
    foreach (plan[i]) transfer(plan[i].cmd, plan[i].typed, plan[i].pixels);

    // random traffic, mostly renders of filled entries
    target     = items_done + RANDOM_ITEMS;
    next_pause = items_done + PAUSE_EVERY;
    while (items_done < target) begin
      if (items_done >= next_pause) begin
        pause_due  = 1'b1;
        next_pause = next_pause + PAUSE_EVERY;
      end
      pick = $urandom_range(0, 99);
      c    = random_command();
      if (pick < 40) begin
        render_filled(ROW_W'($urandom), COLUMN_W'($urandom));
      end else if (pick < 50) begin
        // refresh-like sweep along one row
        r   = ROW_W'($urandom);
        col = COLUMN_W'($urandom);
        repeat ($urandom_range(4, 16)) begin
          render_filled(r, col);
          col = col + 1'b1;
        end
      end else if (pick < 65) begin
        c.action = ACT_MAP_WR;
        if ($urandom_range(0, 4) != 0) c.address = ADDR_W'($urandom_range(0, MAP_DEPTH - 1));
        transfer(c);
      end else if (pick < 80) begin
        c.action = ACT_PAT_WR;
        transfer(c);
      end else if (pick < 90) begin
        c.action = ACT_ROW_SCRL;
        transfer(c);
      end else if (pick < 95) begin
        c.action = ACT_ALL_SCRL;
        transfer(c);
      end else begin
        c.action = ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        transfer(c);
      end
    end

    // wait out the last renders
    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_bytes.size() != 0) begin
      $error("%0d expected bytes never arrived", pending_bytes.size());
      fail_count++;
    end

    $display("ran %0d directed rows and %0d commands in all, %0d rendered bytes checked",
             plan.size(), commands_sent, bytes_checked);
    $display("random map, pattern and scroll writes with %0d full drain pauses", drain_pauses);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/tmsr_pkg.sv
src/tmsr_ram.sv
src/tile_map_scroll_renderer_top.sv
src/tmsr_checker.sv
tb/sv/tb_tile_map_scroll_renderer_top.sv
